### hw/rtl/vtw_pkg.sv
// package: shared widths, codes and controller/datapath interface structs
`timescale 1ns / 1ps

package vtw_pkg;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 6;
    localparam int STATE_W  = 5;
    localparam int LEN_W    = 7;
    localparam int ENTRY_W  = STATE_W + 1;
    localparam int NOPRED_BIT = STATE_W;

    localparam int MAX_POSITIONS_DEF = 64;
    localparam int NUM_STATES_DEF    = 32;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PART  = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic start_full;
        logic start_part;
        logic rd_en;
        logic load_cur;
        logic dec_wp;
        logic emit_cur;
        logic emit_last;
        logic emit_err;
    } dp_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic pos_in_range;
        logic wp_zero;
        logic wp_le_one;
        logic lookup_ok;
        logic skip;
        logic out_free;
    } dp_status_t;

endpackage

### hw/rtl/vtw_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module vtw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/vtw_ctrl.sv
// traceback controller state machine
`timescale 1ns / 1ps

module vtw_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [vtw_pkg::KIND_W-1:0] s_kind,
    input  logic                       s_path_found,
    input  vtw_pkg::dp_status_t        status,
    output vtw_pkg::dp_cmd_t           cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIRST = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_ERROR = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_kind)
                        vtw_pkg::KIND_WRITE: begin
                            cmd.wr_en = 1'b1;
                        end
                        vtw_pkg::KIND_FULL: begin
                            if (!status.len_zero && s_path_found) begin
                                cmd.start_full = 1'b1;
                                state_next     = ST_FIRST;
                            end
                        end
                        vtw_pkg::KIND_PART: begin
                            if (!status.len_zero) begin
                                if (!status.pos_in_range) begin
                                    state_next = ST_ERROR;
                                end else begin
                                    cmd.start_part = 1'b1;
                                    state_next     = ST_READ;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIRST: begin
                // end state of a full traceback
                if (status.out_free) begin
                    cmd.emit_cur  = 1'b1;
                    cmd.emit_last = status.wp_zero;
                    state_next    = status.wp_zero ? ST_IDLE : ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!status.lookup_ok) begin
                    state_next = ST_ERROR;
                end else begin
                    cmd.load_cur = 1'b1;
                    if (status.skip) begin
                        // first partial lookup is checked but not emitted
                        cmd.dec_wp = 1'b1;
                        state_next = status.wp_le_one ? ST_IDLE : ST_READ;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_cur  = 1'b1;
                    cmd.emit_last = status.wp_le_one;
                    cmd.dec_wp    = 1'b1;
                    state_next    = status.wp_le_one ? ST_IDLE : ST_READ;
                end
            end
            ST_ERROR: begin
                if (status.out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/vtw_datapath.sv
// traceback datapath: pointer table, walk registers, output register
`timescale 1ns / 1ps

module vtw_datapath #(
    parameter int MAX_POSITIONS = vtw_pkg::MAX_POSITIONS_DEF,
    parameter int NUM_STATES    = vtw_pkg::NUM_STATES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [vtw_pkg::LEN_W-1:0]   cfg_data,
    input  logic [vtw_pkg::POS_W-1:0]   s_position,
    input  logic [vtw_pkg::STATE_W-1:0] s_state_index,
    input  logic [vtw_pkg::STATE_W-1:0] s_pointer_value,
    input  logic                        s_no_predecessor,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [vtw_pkg::STATE_W-1:0] m_path_state,
    output logic                        m_status,
    output logic                        m_last,
    input  vtw_pkg::dp_cmd_t            cmd,
    output vtw_pkg::dp_status_t         status
);

    localparam int DEPTH = MAX_POSITIONS * NUM_STATES;
    localparam int AW    = $clog2(DEPTH);

    logic [vtw_pkg::LEN_W-1:0]   seq_len_reg;
    logic [vtw_pkg::LEN_W-1:0]   len;
    logic [vtw_pkg::LEN_W-1:0]   wp_reg;
    logic [vtw_pkg::STATE_W-1:0] cur_reg;
    logic                        skip_reg;
    logic                        oob_reg;
    logic                        m_valid_reg;
    logic [vtw_pkg::STATE_W-1:0] m_path_state_reg;
    logic                        m_status_reg;
    logic                        m_last_reg;

    logic                        wr_ok;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic [vtw_pkg::ENTRY_W-1:0] wr_data;
    logic [vtw_pkg::ENTRY_W-1:0] rd_data;
    logic                        out_free;

    // lengths above the table size saturate
    assign len = (32'(seq_len_reg) > MAX_POSITIONS) ? vtw_pkg::LEN_W'(MAX_POSITIONS)
                                                    : seq_len_reg;

    assign wr_ok   = cmd.wr_en && (32'(s_position) < MAX_POSITIONS)
                     && (32'(s_state_index) < NUM_STATES);
    assign wr_addr = AW'(32'(s_position) * 32'(NUM_STATES) + 32'(s_state_index));
    assign wr_data = {s_no_predecessor, s_pointer_value};
    assign rd_addr = AW'(32'(wp_reg) * 32'(NUM_STATES) + 32'(cur_reg));

    vtw_ram #(
        .WIDTH (vtw_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ptr_ram (
        .aclk    (aclk),
        .wr_en   (wr_ok),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg <= '0;
            wp_reg      <= '0;
            cur_reg     <= '0;
            skip_reg    <= 1'b0;
            oob_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                seq_len_reg <= cfg_data;
            end
            if (cmd.start_full) begin
                cur_reg  <= s_state_index;
                wp_reg   <= len - 1'b1;
                skip_reg <= 1'b0;
            end else if (cmd.start_part) begin
                cur_reg  <= s_state_index;
                wp_reg   <= vtw_pkg::LEN_W'(s_position);
                skip_reg <= 1'b1;
            end else begin
                if (cmd.load_cur) begin
                    cur_reg  <= rd_data[vtw_pkg::STATE_W-1:0];
                    skip_reg <= 1'b0;
                end
                if (cmd.dec_wp) begin
                    wp_reg <= wp_reg - 1'b1;
                end
            end
            if (cmd.rd_en) begin
                // lookups off the table read as no predecessor
                oob_reg <= (32'(wp_reg) >= MAX_POSITIONS) || (32'(cur_reg) >= NUM_STATES);
            end
            if (cmd.emit_cur || cmd.emit_err) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_err) begin
            m_path_state_reg <= '0;
            m_status_reg     <= 1'b1;
            m_last_reg       <= 1'b1;
        end else if (cmd.emit_cur) begin
            m_path_state_reg <= cur_reg;
            m_status_reg     <= 1'b0;
            m_last_reg       <= cmd.emit_last;
        end
    end

    assign status.len_zero     = (len == '0);
    assign status.pos_in_range = (vtw_pkg::LEN_W'(s_position) < len);
    assign status.wp_zero      = (wp_reg == '0);
    assign status.wp_le_one    = (wp_reg <= vtw_pkg::LEN_W'(1));
    assign status.lookup_ok    = !oob_reg && !rd_data[vtw_pkg::NOPRED_BIT];
    assign status.skip         = skip_reg;
    assign status.out_free     = out_free;

    assign m_valid      = m_valid_reg;
    assign m_path_state = m_path_state_reg;
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

endmodule

### hw/rtl/viterbi_traceback_walker.sv
// survivor-pointer table with backward traceback walker
// writes: one item per cycle while idle, stored at the accepting edge, no result
// full traceback: end state loaded at accept and emitted from its own state, then per
//   position the table read, pointer check and emit states; the check uses the registered ram read
// partial: first lookup checked, unemitted; then read/check/emit per position; busy till done
// reset clears control and seq_length; table contents are undefined until written
`timescale 1ns / 1ps

module viterbi_traceback_walker #(
    parameter int MAX_POSITIONS = vtw_pkg::MAX_POSITIONS_DEF,
    parameter int NUM_STATES    = vtw_pkg::NUM_STATES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [vtw_pkg::LEN_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [vtw_pkg::KIND_W-1:0]  s_kind,
    input  logic [vtw_pkg::POS_W-1:0]   s_position,
    input  logic [vtw_pkg::STATE_W-1:0] s_state_index,
    input  logic [vtw_pkg::STATE_W-1:0] s_pointer_value,
    input  logic                        s_no_predecessor,
    input  logic                        s_path_found,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vtw_pkg::STATE_W-1:0] m_path_state,
    output logic                        m_status,
    output logic                        m_last
);

    vtw_pkg::dp_cmd_t    cmd;
    vtw_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    vtw_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_path_found (s_path_found),
        .status       (status),
        .cmd          (cmd)
    );

    vtw_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .NUM_STATES    (NUM_STATES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .s_position       (s_position),
        .s_state_index    (s_state_index),
        .s_pointer_value  (s_pointer_value),
        .s_no_predecessor (s_no_predecessor),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_path_state     (m_path_state),
        .m_status         (m_status),
        .m_last           (m_last),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
